>>> design/battery_level_blink_indicator_assert.svh
// assertion macros used by the checker file of battery_level_blink_indicator
// needs a clock named aclk and an active-low synchronous reset named aresetn in scope
`ifndef BATTERY_LEVEL_BLINK_INDICATOR_ASSERT_SVH
`define BATTERY_LEVEL_BLINK_INDICATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BLI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bli_pkg.sv
// shared types, widths, reset values and blink gap tables for the battery level indicator
// no dependencies
package bli_pkg;

    localparam int TS_W       = 32;
    localparam int MV_W       = 16;
    localparam int PHASE_W    = 3;
    localparam int LEVEL_W    = 3;
    localparam int GAP_W      = 10;
    localparam int NUM_THRESH = 8;
    localparam int IDX_W      = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 8;

    // bit positions of the result fields in m_tdata
    localparam int LED_WRITE_BIT = 0;
    localparam int LED_LEVEL_BIT = 1;
    localparam int LOW_BATT_BIT  = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_LVL4_M0,
        REG_LVL3_M0,
        REG_LVL2_M0,
        REG_LVL1_M0,
        REG_LVL4_M1,
        REG_LVL3_M1,
        REG_LVL2_M1,
        REG_LVL1_M1
    } reg_idx_t;

    typedef logic [MV_W-1:0] mv_t;

    typedef struct packed {
        logic low_battery;
        logic led_level;
        logic led_write;
    } result_t;

    localparam mv_t THRESH_RESET [NUM_THRESH] = '{
        16'd7900, 16'd7400, 16'd7000, 16'd6400,
        16'd7800, 16'd7200, 16'd6600, 16'd6000
    };

    // gap before the first pulse of a pattern
    function automatic logic [GAP_W-1:0] idle_gap(input logic [LEVEL_W-1:0] lvl);
        logic [GAP_W-1:0] g;
        case (lvl)
            3'd1:    g = 10'd750;
            3'd2:    g = 10'd490;
            3'd3:    g = 10'd300;
            3'd4:    g = 10'd300;
            default: g = '0;
        endcase
        return g;
    endfunction

    // gap before each later edge of a pattern, within and between pulses
    function automatic logic [GAP_W-1:0] pulse_gap(input logic [LEVEL_W-1:0] lvl);
        logic [GAP_W-1:0] g;
        case (lvl)
            3'd1:    g = 10'd250;
            3'd2:    g = 10'd170;
            3'd3:    g = 10'd140;
            3'd4:    g = 10'd100;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

>>> design/battery_level_blink_indicator.sv
// battery level blink indicator: threshold registers, sample register, blink state and result register
// depends on bli_pkg
//
// channel   direction  transaction content
// s_*       in         timestamp and voltage in tdata, mode in tuser
// m_*       out        led write, led level, low battery flag in tdata
// apb       in/out     eight 16-bit threshold registers at byte address 4*i
//
// one sample per cycle sustained while m_* is ready; an accepted sample loads the sample
// register and then moves into the result register, which drives m_*.
// the blink state updates as the sample moves into the result register,
// so the next sample always sees it. reset clears the blink state and valids and reloads
// the thresholds. a stalled m_* holds the result and the sample register, and s_tready
// drops only when both are full.
module battery_level_blink_indicator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bli_pkg::S_TDATA_W-1:0]   s_tdata,   // now_ms[31:0], battery_mv[47:32]
    input  logic                            s_tuser,   // mode[0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bli_pkg::M_TDATA_W-1:0]   m_tdata,   // led_write[0], led_level[1],
                                                       // low_battery[2], zero fill[7:3]
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bli_pkg::ADDR_W-1:0]      paddr,
    input  logic [bli_pkg::DATA_W-1:0]      pwdata,
    output logic [bli_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import bli_pkg::*;

    mv_t                thresh_reg [NUM_THRESH];

    logic               in_valid_reg;
    logic [TS_W-1:0]    in_now_reg;
    logic               in_mode_reg;
    mv_t                in_mv_reg;

    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result_next;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [TS_W-1:0]    last_reg;
    logic [TS_W-1:0]    last_next;

    logic               advance;
    logic               s_accept;
    logic               cfg_wr;

    mv_t                t4, t3, t2, t1;
    logic [LEVEL_W-1:0] level;
    logic [PHASE_W:0]   phases;
    logic [GAP_W-1:0]   gap;
    logic [TS_W-1:0]    elapsed;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = DATA_W'(thresh_reg[paddr[IDX_W+1:2]]);

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(result_reg);

    // level decode, highest threshold first
    always_comb begin
        t4 = in_mode_reg ? thresh_reg[REG_LVL4_M1] : thresh_reg[REG_LVL4_M0];
        t3 = in_mode_reg ? thresh_reg[REG_LVL3_M1] : thresh_reg[REG_LVL3_M0];
        t2 = in_mode_reg ? thresh_reg[REG_LVL2_M1] : thresh_reg[REG_LVL2_M0];
        t1 = in_mode_reg ? thresh_reg[REG_LVL1_M1] : thresh_reg[REG_LVL1_M0];
        if (in_mv_reg > t4) begin
            level = 3'd4;
        end else if (in_mv_reg > t3) begin
            level = 3'd3;
        end else if (in_mv_reg > t2) begin
            level = 3'd2;
        end else if (in_mv_reg > t1) begin
            level = 3'd1;
        end else begin
            level = 3'd0;
        end
    end

    always_comb begin
        result_next = '0;
        phase_next  = phase_reg;
        last_next   = last_reg;
        phases      = {level, 1'b0};
        gap         = (phase_reg == '0) ? idle_gap(level) : pulse_gap(level);
        elapsed     = in_now_reg - last_reg;
        if (level == '0) begin
            result_next.low_battery = 1'b1;
        end else if ({1'b0, phase_reg} >= phases) begin
            // level dropped under the current phase: restart the pattern quietly
            phase_next = '0;
            last_next  = in_now_reg;
        end else if (elapsed > TS_W'(gap)) begin
            result_next.led_write = 1'b1;
            result_next.led_level = ~phase_reg[0];
            phase_next = (({1'b0, phase_reg} + 1'b1) == phases) ? '0 : phase_reg + 1'b1;
            last_next  = in_now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            last_reg      <= '0;
            for (int i = 0; i < NUM_THRESH; i++) begin
                thresh_reg[i] <= THRESH_RESET[i];
            end
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                last_reg      <= last_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                thresh_reg[paddr[IDX_W+1:2]] <= pwdata[MV_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_now_reg  <= s_tdata[TS_W-1:0];
            in_mv_reg   <= s_tdata[TS_W+MV_W-1:TS_W];
            in_mode_reg <= s_tuser;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

endmodule

>>> design/bli_checker.sv
// port-level checks for battery_level_blink_indicator, bound to the top level
// depends on bli_pkg and battery_level_blink_indicator_assert.svh
`include "battery_level_blink_indicator_assert.svh"

module bli_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bli_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          pready
);
    import bli_pkg::*;

    // the led level only means something on a write
    `BLI_ASSERT_SAME(a_level_needs_write, m_tvalid && m_tdata[LED_LEVEL_BIT], m_tdata[LED_WRITE_BIT], "led level set without led write")
    // a low battery result never drives the led
    `BLI_ASSERT_SAME(a_low_no_write, m_tvalid && m_tdata[LOW_BATT_BIT], !m_tdata[LED_WRITE_BIT], "led written on low battery")
    // unused result bits stay zero
    `BLI_ASSERT_SAME(a_fill_zero, m_tvalid, m_tdata[M_TDATA_W-1:LOW_BATT_BIT+1] == '0, "nonzero fill bits in result")
    `BLI_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")
    `BLI_ASSERT_SAME(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind battery_level_blink_indicator bli_checker u_bli_checker (.*);

>>> tb/tb_battery_level_blink_indicator.sv
// self-checking testbench for battery_level_blink_indicator: directed table, then random phases
// with reprogrammed thresholds and random idling, each result checked against a local predictor or
// the table's typed result; depends on bli_pkg and the battery_level_blink_indicator rtl
module tb_battery_level_blink_indicator;
    import bli_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 235;
    localparam int WATCHDOG_MAX = 2000;
    localparam int DIRECTED_N   = 21;

    localparam result_t NO_WRITE_RES = '{low_battery: 1'b0, led_level: 1'b0, led_write: 1'b0};
    localparam result_t LOW_BATT_RES = '{low_battery: 1'b1, led_level: 1'b0, led_write: 1'b0};

    typedef enum {
        CFG_KEEP, CFG_ZERO, CFG_FULL, CFG_ORDERED, CFG_SHUFFLED, CFG_DEFAULT, CFG_TOP_ONLY
    } thresh_plan_t;

    typedef struct {
        logic [31:0] now;
        logic        mode;
        mv_t         mv;
        bit          typed;
        result_t     res;
    } sample_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // now_ms[31:0], battery_mv[47:32]
    logic                  s_tuser  = 1'b0; // mode[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // led_write[0], led_level[1], low_battery[2]
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [DATA_W-1:0]     pwdata   = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    battery_level_blink_indicator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    mv_t         thresh_mv [NUM_THRESH];
    logic [31:0] last_toggle;
    logic [2:0]  led_phase;
    int unsigned idle_ms  [1:4] = '{750, 490, 300, 300};
    int unsigned pulse_ms [1:4] = '{250, 170, 140, 100};

    result_t blink_expected [$];
    int      mismatches    = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      quiet_cycles  = 0;

    function automatic result_t predict_blink(input logic [31:0] now, input logic m,
                                              input mv_t mv);
        result_t     r;
        int          lvl;
        int          phases;
        logic [31:0] gap;
        logic [31:0] elapsed;
        r   = NO_WRITE_RES;
        lvl = 0;
        // thresholds tested from level four down, first hit wins
        for (int k = 0; k < 4; k++)
            if (lvl == 0 && mv > thresh_mv[m*4 + k]) lvl = 4 - k;
        if (lvl == 0) begin
            r.low_battery = 1'b1;
            return r;
        end
        phases = 2 * lvl;
        if (int'(led_phase) >= phases) begin
            led_phase   = '0;
            last_toggle = now;
            return r;
        end
        gap     = (led_phase == 0) ? idle_ms[lvl] : pulse_ms[lvl];
        elapsed = now - last_toggle;
        if (elapsed > gap) begin
            r.led_write = 1'b1;
            r.led_level = ~led_phase[0];
            led_phase   = (int'(led_phase) + 1 == phases) ? 3'd0 : led_phase + 3'd1;
            last_toggle = now;
        end
        return r;
    endfunction

    // voltage just above the threshold of the wanted level, or at or below the lowest one
    function automatic mv_t pick_mv(input logic m, input int lvl);
        mv_t         t;
        logic [16:0] v;
        if (lvl == 0) return mv_t'($urandom_range(0, thresh_mv[m*4 + 3]));
        t = thresh_mv[m*4 + (4 - lvl)];
        v = {1'b0, t} + 17'd1
            + 17'((($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) : 0));
        return (v > 17'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    task automatic send_sample(input logic [31:0] now, input logic m, input mv_t mv,
                               input bit typed, input result_t res);
        result_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mv, now};
        s_tuser  <= m;
        do @(posedge aclk); while (!s_tready);
        want = predict_blink(now, m, mv);
        blink_expected.push_back(typed ? res : want);
    endtask

    task automatic apb_write(input reg_idx_t idx, input mv_t v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        thresh_mv[idx] = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic report_field(input string name, input logic want, input logic got);
        $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
        mismatches++;
    endtask

    // result checking and receiver stalls
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.led_write   = m_tdata[LED_WRITE_BIT];
            got.led_level   = m_tdata[LED_LEVEL_BIT];
            got.low_battery = m_tdata[LOW_BATT_BIT];
            if (blink_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %b", $time, got);
                mismatches++;
            end else begin
                want = blink_expected.pop_front();
                if (got.led_write !== want.led_write)
                    report_field("led_write", want.led_write, got.led_write);
                if (got.led_level !== want.led_level)
                    report_field("led_level", want.led_level, got.led_level);
                if (got.low_battery !== want.low_battery)
                    report_field("low_battery", want.low_battery, got.low_battery);
            end
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("tb_battery_level_blink_indicator failed");
            $finish;
        end
    end

    sample_row_t directed_rows [DIRECTED_N] = '{
        '{32'd0,         1'b0, 16'd0,     1'b1, LOW_BATT_RES},
        '{32'd0,         1'b1, 16'hFFFF,  1'b1, NO_WRITE_RES},
        '{32'd301,       1'b0, 16'd8000,  1'b0, NO_WRITE_RES},
        '{32'd401,       1'b0, 16'd8000,  1'b0, NO_WRITE_RES},
        '{32'd402,       1'b0, 16'd7900,  1'b0, NO_WRITE_RES},
        '{32'd543,       1'b0, 16'd7401,  1'b0, NO_WRITE_RES},
        '{32'd700,       1'b1, 16'd7801,  1'b0, NO_WRITE_RES},
        '{32'd800,       1'b1, 16'd6001,  1'b0, NO_WRITE_RES},
        '{32'd1550,      1'b1, 16'd6001,  1'b0, NO_WRITE_RES},
        '{32'd1551,      1'b1, 16'd6001,  1'b0, NO_WRITE_RES},
        '{32'hFFFF_FFFF, 1'b0, 16'd6401,  1'b0, NO_WRITE_RES},
        '{32'd750,       1'b0, 16'd6401,  1'b0, NO_WRITE_RES},
        '{32'd800,       1'b0, 16'd6400,  1'b1, LOW_BATT_RES},
        '{32'd1001,      1'b0, 16'd6401,  1'b0, NO_WRITE_RES},
        '{32'd1492,      1'b0, 16'd7001,  1'b0, NO_WRITE_RES},
        '{32'd1662,      1'b0, 16'd7001,  1'b0, NO_WRITE_RES},
        '{32'd1663,      1'b0, 16'd7001,  1'b0, NO_WRITE_RES},
        '{32'd1834,      1'b0, 16'd7001,  1'b0, NO_WRITE_RES},
        '{32'd2005,      1'b0, 16'd7001,  1'b0, NO_WRITE_RES},
        '{32'd2005,      1'b1, 16'd0,     1'b1, LOW_BATT_RES},
        '{32'd2306,      1'b1, 16'd7201,  1'b0, NO_WRITE_RES}
    };

    thresh_plan_t phase_plan [PHASES] = '{
        CFG_KEEP, CFG_ZERO, CFG_ORDERED, CFG_FULL,
        CFG_SHUFFLED, CFG_TOP_ONLY, CFG_ORDERED, CFG_DEFAULT
    };

    initial begin
        logic [31:0] now_ms;
        logic        cur_mode;
        int          target_lvl;
        mv_t         vals [NUM_THRESH];
        mv_t         mv;
        logic [16:0] acc;

        for (int r = 0; r < NUM_THRESH; r++) thresh_mv[r] = THRESH_RESET[r];
        last_toggle = '0;
        led_phase   = '0;
        now_ms      = '0;
        cur_mode    = 1'b0;
        target_lvl  = 4;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].now, directed_rows[i].mode, directed_rows[i].mv,
                        directed_rows[i].typed, directed_rows[i].res);
        now_ms = directed_rows[DIRECTED_N-1].now;

        for (int p = 0; p < PHASES; p++) begin
            if (phase_plan[p] != CFG_KEEP) begin
                // thresholds change only with the pipeline drained
                s_tvalid <= 1'b0;
                while (blink_expected.size() != 0) @(posedge aclk);
                for (int m = 0; m < 2; m++) begin
                    acc = 17'($urandom_range(0, 60000));
                    for (int k = 3; k >= 0; k--) begin
                        case (phase_plan[p])
                            CFG_ZERO:     vals[m*4 + k] = 16'h0000;
                            CFG_FULL:     vals[m*4 + k] = 16'hFFFF;
                            CFG_SHUFFLED: vals[m*4 + k] = mv_t'($urandom);
                            CFG_DEFAULT:  vals[m*4 + k] = THRESH_RESET[m*4 + k];
                            CFG_TOP_ONLY: vals[m*4 + k] = (k == 0) ? 16'hFFFF
                                                                   : mv_t'($urandom_range(0, 20));
                            default: begin
                                // ascending from level one up
                                vals[m*4 + k] = (acc > 17'hFFFF) ? 16'hFFFF : acc[15:0];
                                acc = acc + 17'($urandom_range(1, 1500));
                            end
                        endcase
                    end
                end
                for (int r = 0; r < NUM_THRESH; r++) apb_write(reg_idx_t'(r), vals[r]);
            end

            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    while (blink_expected.size() != 0) @(posedge aclk);
                end
                if ($urandom_range(0, 19) == 0) cur_mode = ~cur_mode;
                if ($urandom_range(0, 24) == 0) target_lvl = $urandom_range(0, 4);
                case ($urandom_range(0, 49))
                    0, 1:    now_ms = $urandom;
                    2:       now_ms = 32'hFFFF_FE00 + $urandom_range(0, 255);
                    default: now_ms = now_ms + $urandom_range(0, 350);
                endcase
                mv = ($urandom_range(0, 9) == 0) ? mv_t'($urandom) : pick_mv(cur_mode, target_lvl);
                send_sample(now_ms, cur_mode, mv, 1'b0, NO_WRITE_RES);
            end
        end

        s_tvalid <= 1'b0;
        while (blink_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && blink_expected.size() == 0)
            $display("tb_battery_level_blink_indicator passed");
        else
            $display("tb_battery_level_blink_indicator failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bli_pkg.sv
design/battery_level_blink_indicator.sv
design/bli_checker.sv
tb/tb_battery_level_blink_indicator.sv
